>>> rtl/core/tbdw_pkg.sv
package tbdw_pkg;

  typedef logic [31:0] word_t;

  // Full 128-bit key as four words
  typedef struct packed {
    word_t k3;
    word_t k2;
    word_t k1;
    word_t k0;
  } key_t;

  localparam word_t TEA_DELTA   = 32'h9E3779B9;
  localparam word_t KEY_RESET_A = 32'h313A7854;
  localparam word_t KEY_RESET_B = 32'h35343332;

  localparam int    RC_W           = 6;
  localparam int    MAX_ROUNDS_DEF = 32;
  localparam int    ROUNDS_W_DEF   = $clog2(MAX_ROUNDS_DEF + 1);
  localparam logic [RC_W-1:0] RC_RESET = 6'd16;

  localparam int    CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_ROUNDS = 3'd4,
    CFG_WSEL   = 3'd5
  } cfg_idx_t;

  // TEA mixing term
  function automatic word_t tea_mix(word_t v, word_t ka, word_t kb, word_t sum);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

>>> rtl/core/tbdw_if.sv
// Encrypted block channel
interface tbdw_cipher_if;
  logic               valid;
  logic               ready;
  tbdw_pkg::word_t    cipher_word_low;
  tbdw_pkg::word_t    cipher_word_high;

  modport source (output valid, output cipher_word_low, output cipher_word_high,
                  input ready);
  modport sink   (input valid, input cipher_word_low, input cipher_word_high,
                  output ready);
endinterface

// Decrypted block channel
interface tbdw_plain_if;
  logic               valid;
  logic               ready;
  tbdw_pkg::word_t    plain_word_low;
  tbdw_pkg::word_t    plain_word_high;

  modport source (output valid, output plain_word_low, output plain_word_high,
                  input ready);
  modport sink   (input valid, input plain_word_low, input plain_word_high,
                  output ready);
endinterface

>>> rtl/core/tbdw_entry.sv
module tbdw_entry #(
  parameter int MAX_ROUNDS = tbdw_pkg::MAX_ROUNDS_DEF,
  parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  tbdw_pkg::word_t             v0_i,
  input  tbdw_pkg::word_t             v1_i,
  input  tbdw_pkg::key_t              key,
  input  logic [tbdw_pkg::RC_W-1:0]   round_count,
  input  logic                        whiten_select,
  output logic                        valid_o,
  output tbdw_pkg::word_t             v0_o,
  output tbdw_pkg::word_t             v1_o,
  output tbdw_pkg::word_t             sum_o,
  output logic [RW-1:0]               rem_o
);

  localparam int CW = tbdw_pkg::RC_W + 1;

  logic                 valid_r, valid_nxt;
  tbdw_pkg::word_t      v0_r, v0_nxt;
  tbdw_pkg::word_t      v1_r, v1_nxt;
  tbdw_pkg::word_t      sum_r, sum_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        rc_ext;
  logic [RW-1:0]        rounds_sat;
  tbdw_pkg::word_t      wh_lo, wh_hi;

  // Clamp round count, pick whitening pair, compute starting sum
  always_comb begin
    rc_ext     = {1'b0, round_count};
    rounds_sat = (rc_ext > CW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(rc_ext);
    wh_lo      = whiten_select ? key.k2 : key.k0;
    wh_hi      = whiten_select ? key.k3 : key.k1;
    valid_nxt  = valid_i;
    rem_nxt    = rounds_sat;
    sum_nxt    = 32'(tbdw_pkg::TEA_DELTA * 32'(rounds_sat));
    if (rounds_sat != '0) begin
      v0_nxt = v0_i ^ wh_lo;
      v1_nxt = v1_i ^ wh_hi;
    end else begin
      v0_nxt = v0_i;
      v1_nxt = v1_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r  <= v0_nxt;
      v1_r  <= v1_nxt;
      sum_r <= sum_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign valid_o = valid_r;
  assign v0_o    = v0_r;
  assign v1_o    = v1_r;
  assign sum_o   = sum_r;
  assign rem_o   = rem_r;

endmodule

>>> rtl/core/tbdw_round.sv
module tbdw_round #(
  parameter int RW = tbdw_pkg::ROUNDS_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tbdw_pkg::key_t    key,
  input  logic              valid_i,
  input  tbdw_pkg::word_t   v0_i,
  input  tbdw_pkg::word_t   v1_i,
  input  tbdw_pkg::word_t   sum_i,
  input  logic [RW-1:0]     rem_i,
  output logic              valid_o,
  output tbdw_pkg::word_t   v0_o,
  output tbdw_pkg::word_t   v1_o,
  output tbdw_pkg::word_t   sum_o,
  output logic [RW-1:0]     rem_o
);

  // First half: update high word
  logic              va_r, va_nxt;
  tbdw_pkg::word_t   v0a_r, v0a_nxt;
  tbdw_pkg::word_t   v1a_r, v1a_nxt;
  tbdw_pkg::word_t   suma_r, suma_nxt;
  logic [RW-1:0]     rema_r, rema_nxt;

  // Second half: update low word, step the sum
  logic              vb_r, vb_nxt;
  tbdw_pkg::word_t   v0b_r, v0b_nxt;
  tbdw_pkg::word_t   v1b_r, v1b_nxt;
  tbdw_pkg::word_t   sumb_r, sumb_nxt;
  logic [RW-1:0]     remb_r, remb_nxt;

  always_comb begin
    va_nxt   = valid_i;
    v0a_nxt  = v0_i;
    suma_nxt = sum_i;
    rema_nxt = rem_i;
    if (rem_i != '0) begin
      v1a_nxt = v1_i - tbdw_pkg::tea_mix(v0_i, key.k2, key.k3, sum_i);
    end else begin
      v1a_nxt = v1_i;
    end
  end

  always_comb begin
    vb_nxt  = va_r;
    v1b_nxt = v1a_r;
    if (rema_r != '0) begin
      v0b_nxt  = v0a_r - tbdw_pkg::tea_mix(v1a_r, key.k0, key.k1, suma_r);
      sumb_nxt = suma_r - tbdw_pkg::TEA_DELTA;
      remb_nxt = rema_r - RW'(1);
    end else begin
      v0b_nxt  = v0a_r;
      sumb_nxt = suma_r;
      remb_nxt = rema_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0a_r  <= v0a_nxt;
      v1a_r  <= v1a_nxt;
      suma_r <= suma_nxt;
      rema_r <= rema_nxt;
      v0b_r  <= v0b_nxt;
      v1b_r  <= v1b_nxt;
      sumb_r <= sumb_nxt;
      remb_r <= remb_nxt;
    end
  end

  assign valid_o = vb_r;
  assign v0_o    = v0b_r;
  assign v1_o    = v1b_r;
  assign sum_o   = sumb_r;
  assign rem_o   = remb_r;

endmodule

>>> rtl/core/tbdw_out_buf.sv
module tbdw_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pipe_valid,
  input  tbdw_pkg::word_t   pipe_v0,
  input  tbdw_pkg::word_t   pipe_v1,
  output logic              pipe_en,
  tbdw_plain_if.source      out_blk
);

  logic              out_v_r, out_v_nxt;
  tbdw_pkg::word_t   out_lo_r, out_lo_nxt;
  tbdw_pkg::word_t   out_hi_r, out_hi_nxt;
  logic              skid_v_r, skid_v_nxt;
  tbdw_pkg::word_t   skid_lo_r, skid_lo_nxt;
  tbdw_pkg::word_t   skid_hi_r, skid_hi_nxt;
  logic              out_fire;

  assign out_fire = out_v_r & out_blk.ready;
  assign pipe_en  = ~skid_v_r;

  // Drain the skid slot first; otherwise take the pipeline's item
  always_comb begin
    out_v_nxt   = out_v_r;
    out_lo_nxt  = out_lo_r;
    out_hi_nxt  = out_hi_r;
    skid_v_nxt  = skid_v_r;
    skid_lo_nxt = skid_lo_r;
    skid_hi_nxt = skid_hi_r;
    if (skid_v_r) begin
      if (out_fire) begin
        out_lo_nxt = skid_lo_r;
        out_hi_nxt = skid_hi_r;
        skid_v_nxt = 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_v_r || out_fire) begin
        out_v_nxt  = 1'b1;
        out_lo_nxt = pipe_v0;
        out_hi_nxt = pipe_v1;
      end else begin
        skid_v_nxt  = 1'b1;
        skid_lo_nxt = pipe_v0;
        skid_hi_nxt = pipe_v1;
      end
    end else if (out_fire) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_lo_r  <= out_lo_nxt;
    out_hi_r  <= out_hi_nxt;
    skid_lo_r <= skid_lo_nxt;
    skid_hi_r <= skid_hi_nxt;
  end

  assign out_blk.valid           = out_v_r;
  assign out_blk.plain_word_low  = out_lo_r;
  assign out_blk.plain_word_high = out_hi_r;

endmodule

>>> rtl/core/tea_block_decrypt_whitened.sv
// Pipeline: the entry register loads at the accept edge, then two register stages per TEA
// round and the output register follow.
// Throughput: one item per cycle; every round stage is unrolled, so a new item enters
// each cycle while the output side is taking items.
// Reset (rst_n, synchronous): clears all valid bits and loads the configuration
// registers with their default key, 16 rounds and whitening pair 0/1.
module tea_block_decrypt_whitened #(
  parameter int MAX_ROUNDS = tbdw_pkg::MAX_ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tbdw_cipher_if.sink                       in_blk,
  tbdw_plain_if.source                      out_blk,
  input  logic                              cfg_we,
  input  logic [tbdw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  tbdw_pkg::word_t                   cfg_data
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  tbdw_pkg::key_t                  key_r, key_nxt;
  logic [tbdw_pkg::RC_W-1:0]       rc_r, rc_nxt;
  logic                            wsel_r, wsel_nxt;
  logic                            pipe_en;

  logic                            st_valid [MAX_ROUNDS+1];
  tbdw_pkg::word_t                 st_v0    [MAX_ROUNDS+1];
  tbdw_pkg::word_t                 st_v1    [MAX_ROUNDS+1];
  tbdw_pkg::word_t                 st_sum   [MAX_ROUNDS+1];
  logic [RW-1:0]                   st_rem   [MAX_ROUNDS+1];

  // Configuration writes
  always_comb begin
    key_nxt  = key_r;
    rc_nxt   = rc_r;
    wsel_nxt = wsel_r;
    if (cfg_we) begin
      case (tbdw_pkg::cfg_idx_t'(cfg_index))
        tbdw_pkg::CFG_KEY0:   key_nxt.k0 = cfg_data;
        tbdw_pkg::CFG_KEY1:   key_nxt.k1 = cfg_data;
        tbdw_pkg::CFG_KEY2:   key_nxt.k2 = cfg_data;
        tbdw_pkg::CFG_KEY3:   key_nxt.k3 = cfg_data;
        tbdw_pkg::CFG_ROUNDS: rc_nxt     = cfg_data[tbdw_pkg::RC_W-1:0];
        tbdw_pkg::CFG_WSEL:   wsel_nxt   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.k0 <= tbdw_pkg::KEY_RESET_A;
      key_r.k1 <= tbdw_pkg::KEY_RESET_B;
      key_r.k2 <= tbdw_pkg::KEY_RESET_A;
      key_r.k3 <= tbdw_pkg::KEY_RESET_B;
      rc_r     <= tbdw_pkg::RC_RESET;
      wsel_r   <= 1'b0;
    end else begin
      key_r    <= key_nxt;
      rc_r     <= rc_nxt;
      wsel_r   <= wsel_nxt;
    end
  end

  assign in_blk.ready = pipe_en;

  // Whitening and starting sum
  tbdw_entry #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .RW         (RW)
  ) u_entry (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (pipe_en),
    .valid_i       (in_blk.valid),
    .v0_i          (in_blk.cipher_word_low),
    .v1_i          (in_blk.cipher_word_high),
    .key           (key_r),
    .round_count   (rc_r),
    .whiten_select (wsel_r),
    .valid_o       (st_valid[0]),
    .v0_o          (st_v0[0]),
    .v1_o          (st_v1[0]),
    .sum_o         (st_sum[0]),
    .rem_o         (st_rem[0])
  );

  // One unrolled round per slot; inactive rounds pass the item through
  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
    tbdw_round #(
      .RW (RW)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .key     (key_r),
      .valid_i (st_valid[g]),
      .v0_i    (st_v0[g]),
      .v1_i    (st_v1[g]),
      .sum_i   (st_sum[g]),
      .rem_i   (st_rem[g]),
      .valid_o (st_valid[g+1]),
      .v0_o    (st_v0[g+1]),
      .v1_o    (st_v1[g+1]),
      .sum_o   (st_sum[g+1]),
      .rem_o   (st_rem[g+1])
    );
  end

  // Output register with skid slot
  tbdw_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (st_valid[MAX_ROUNDS]),
    .pipe_v0    (st_v0[MAX_ROUNDS]),
    .pipe_v1    (st_v1[MAX_ROUNDS]),
    .pipe_en    (pipe_en),
    .out_blk    (out_blk)
  );

endmodule
